FILE: design/fsr_pkg.sv
// Shared types, constants and helpers of the fan-out sample ring.
package fsr_pkg;

  localparam int Depth      = 4096;
  localparam int Fanout     = 8;
  localparam int SampleBits = 32;
  localparam int MaxBurst   = 64;

  localparam int AddrW  = $clog2(Depth);
  localparam int CapW   = AddrW + 1;
  localparam int CurW   = (Fanout > 1) ? $clog2(Fanout) : 1;
  localparam int PosW   = 64;
  localparam int BurstW = $clog2(MaxBurst + 1);

  // Fixed field widths of the stream payload.
  localparam int ActionW  = 3;
  localparam int SelW     = 3;
  localparam int CountW   = 7;
  localparam int StatusW  = 2;
  localparam int PendW    = 32;
  localparam int CapLog2W = 4;
  localparam int InDataW  = 48;
  localparam int OutDataW = 72;

  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = FifoPtrW + 1;

  localparam logic [CapLog2W-1:0] CapLog2Reset = CapLog2W'(12);

  typedef enum logic [ActionW-1:0] {
    ACT_WRITE  = 3'd0,
    ACT_ATTACH = 3'd1,
    ACT_DETACH = 3'd2,
    ACT_READ   = 3'd3,
    ACT_AVAIL  = 3'd4
  } action_e;

  typedef enum logic [StatusW-1:0] {
    STS_OK      = 2'd0,
    STS_EMPTY   = 2'd1,
    STS_ERR     = 2'd2,
    STS_NO_FREE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_BURST
  } state_e;

  typedef enum logic [2:0] {
    CUR_NOP,
    CUR_WRITE,
    CUR_ATTACH,
    CUR_DETACH,
    CUR_MARK,
    CUR_STEP
  } cur_op_e;

  typedef struct packed {
    cur_op_e         op;
    logic [SelW-1:0] sel;
  } cur_cmd_t;

  typedef struct packed {
    logic             free_found;
    logic [CurW-1:0]  free_idx;
    logic             sel_active;
    logic             sel_overrun;
    logic [PosW-1:0]  sel_lag;
    logic [AddrW-1:0] sel_addr;
    logic [AddrW-1:0] wr_addr;
  } cur_stat_t;

  typedef struct packed {
    status_e               status;
    logic [SampleBits-1:0] sample;
    logic [SelW-1:0]       cursor;
    logic [PendW-1:0]      pending;
    logic                  last;
  } res_t;

  function automatic logic [PendW-1:0] sat32(input logic [PosW-1:0] v);
    logic [PendW-1:0] r;
    r = (v[PosW-1:PendW] != '0) ? '1 : v[PendW-1:0];
    return r;
  endfunction

endpackage

FILE: design/fanout_sample_ring.sv
// Sample ring with one writer and eight reader cursors. An accepted transaction
// is executed in the cycle after acceptance; an item with one result waits there
// while the result queue is full, and a new transaction is taken in the cycle
// after that result is pushed. In a read burst, after the execute cycle, the
// sequencer issues one read per cycle on the single read port of the 4096-word
// sample store, as long as the four-entry result queue has room, counting a
// read still in flight. Results stall only when that queue is full. The sample
// store is not cleared after reset; there is no clearing pass.
module fanout_sample_ring (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fsr_pkg::CapLog2W-1:0]    cfg_wdata_i,    // capacity_log2
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [fsr_pkg::InDataW-1:0]     s_axis_tdata_i, // sample_in, cursor_sel, count
  input  logic [fsr_pkg::ActionW-1:0]     s_axis_tuser_i, // action
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [fsr_pkg::OutDataW-1:0]    m_axis_tdata_o, // sample_out, cursor_out, pending
  output logic [fsr_pkg::StatusW-1:0]     m_axis_tuser_o, // status
  output logic                            m_axis_tlast_o
);

  fsr_pkg::state_e                state_q, state_d;
  logic [fsr_pkg::CapLog2W-1:0]   cap_log2_q;
  logic [fsr_pkg::CapLog2W-1:0]   cap_log2_eff;
  logic [fsr_pkg::CapW-1:0]       cap;
  logic [fsr_pkg::AddrW-1:0]      mask;

  logic [fsr_pkg::ActionW-1:0]    action_q;
  logic [fsr_pkg::SampleBits-1:0] sample_q;
  logic [fsr_pkg::SelW-1:0]       sel_q;
  logic [fsr_pkg::CountW-1:0]     count_q;
  logic [fsr_pkg::BurstW-1:0]     rem_q, rem_d;

  logic                           rd_pend_q, rd_pend_d;
  logic [fsr_pkg::PendW-1:0]      pend_pending_q, pend_pending_d;
  logic                           pend_last_q, pend_last_d;

  fsr_pkg::cur_cmd_t              cur_cmd;
  fsr_pkg::cur_stat_t             cur_stat;

  logic                           ram_we, ram_re;
  logic [fsr_pkg::AddrW-1:0]      ram_raddr;
  logic [fsr_pkg::SampleBits-1:0] ram_rdata;

  logic                           exec_push, fifo_push;
  fsr_pkg::res_t                  exec_res, fifo_data, fifo_out;
  logic                           fifo_valid;
  logic [fsr_pkg::FifoCntW-1:0]   fifo_cnt;

  logic                           exec_space, issue_ok, known_action;
  logic                           read_err, read_mark, read_empty, burst_go;
  logic [fsr_pkg::CountW-1:0]     count_sat;
  logic [fsr_pkg::BurstW-1:0]     burst_n;
  logic [fsr_pkg::PosW-1:0]       lag_left;

  // Capacity requests above the store depth saturate to the depth.
  always_comb begin
    cap_log2_eff = (32'(cap_log2_q) > fsr_pkg::AddrW) ?
                   fsr_pkg::CapLog2W'(fsr_pkg::AddrW) : cap_log2_q;
    cap          = fsr_pkg::CapW'(1) << cap_log2_eff;
    mask         = fsr_pkg::AddrW'(cap - 1'b1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_log2_q <= fsr_pkg::CapLog2Reset;
    end else if (cfg_we_i) begin
      cap_log2_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      action_q <= s_axis_tuser_i;
      sample_q <= s_axis_tdata_i[31:0];
      sel_q    <= s_axis_tdata_i[34:32];
      count_q  <= s_axis_tdata_i[41:35];
    end
    pend_pending_q <= pend_pending_d;
    pend_last_q    <= pend_last_d;
  end

  // Decode of the held transaction against the cursor table.
  always_comb begin
    exec_space   = (fifo_cnt < fsr_pkg::FifoCntW'(fsr_pkg::FifoDepth));
    issue_ok     = (fifo_cnt + fsr_pkg::FifoCntW'(rd_pend_q)) <
                   fsr_pkg::FifoCntW'(fsr_pkg::FifoDepth);
    known_action = (action_q == fsr_pkg::ACT_WRITE)  || (action_q == fsr_pkg::ACT_ATTACH) ||
                   (action_q == fsr_pkg::ACT_DETACH) || (action_q == fsr_pkg::ACT_READ) ||
                   (action_q == fsr_pkg::ACT_AVAIL);
    read_err     = !cur_stat.sel_active || cur_stat.sel_overrun;
    read_mark    = !read_err && (cur_stat.sel_lag > fsr_pkg::PosW'(cap));
    read_empty   = !read_err && !read_mark &&
                   ((cur_stat.sel_lag == '0) || (count_q == '0));
    burst_go     = (action_q == fsr_pkg::ACT_READ) && !read_err && !read_mark && !read_empty;
    count_sat    = (32'(count_q) > fsr_pkg::MaxBurst) ?
                   fsr_pkg::CountW'(fsr_pkg::MaxBurst) : count_q;
    burst_n      = (cur_stat.sel_lag < fsr_pkg::PosW'(count_sat)) ?
                   fsr_pkg::BurstW'(cur_stat.sel_lag) : fsr_pkg::BurstW'(count_sat);
    lag_left     = cur_stat.sel_lag - 1'b1;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fsr_pkg::ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          state_d = fsr_pkg::ST_EXEC;
        end
      end
      fsr_pkg::ST_EXEC: begin
        if (!known_action) begin
          state_d = fsr_pkg::ST_IDLE;
        end else if (burst_go) begin
          state_d = fsr_pkg::ST_BURST;
        end else if (exec_space) begin
          state_d = fsr_pkg::ST_IDLE;
        end
      end
      fsr_pkg::ST_BURST: begin
        if (issue_ok && (rem_q == fsr_pkg::BurstW'(1))) begin
          state_d = fsr_pkg::ST_IDLE;
        end
      end
      default: state_d = fsr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready_o = 1'b0;
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    ram_raddr       = cur_stat.sel_addr & mask;
    cur_cmd.op      = fsr_pkg::CUR_NOP;
    cur_cmd.sel     = sel_q;
    exec_push       = 1'b0;
    exec_res        = '0;
    exec_res.last   = 1'b1;
    rem_d           = rem_q;
    rd_pend_d       = 1'b0;
    pend_pending_d  = pend_pending_q;
    pend_last_d     = pend_last_q;
    unique case (state_q)
      fsr_pkg::ST_IDLE: begin
        s_axis_tready_o = 1'b1;
      end
      fsr_pkg::ST_EXEC: begin
        if (burst_go) begin
          rem_d = burst_n;
        end else if (exec_space && known_action) begin
          exec_push = 1'b1;
          unique case (action_q)
            fsr_pkg::ACT_WRITE: begin
              ram_we     = 1'b1;
              cur_cmd.op = fsr_pkg::CUR_WRITE;
            end
            fsr_pkg::ACT_ATTACH: begin
              if (cur_stat.free_found) begin
                cur_cmd.op      = fsr_pkg::CUR_ATTACH;
                exec_res.cursor = fsr_pkg::SelW'(cur_stat.free_idx);
              end else begin
                exec_res.status = fsr_pkg::STS_NO_FREE;
              end
            end
            fsr_pkg::ACT_DETACH: begin
              cur_cmd.op = fsr_pkg::CUR_DETACH;
            end
            fsr_pkg::ACT_READ: begin
              if (read_err) begin
                exec_res.status = fsr_pkg::STS_ERR;
              end else if (read_mark) begin
                cur_cmd.op      = fsr_pkg::CUR_MARK;
                exec_res.status = fsr_pkg::STS_ERR;
              end else begin
                exec_res.status  = fsr_pkg::STS_EMPTY;
                exec_res.pending = fsr_pkg::sat32(cur_stat.sel_lag);
              end
            end
            default: begin
              if (cur_stat.sel_active) begin
                exec_res.pending = fsr_pkg::sat32(cur_stat.sel_lag);
              end else begin
                exec_res.status = fsr_pkg::STS_ERR;
              end
            end
          endcase
        end
      end
      fsr_pkg::ST_BURST: begin
        // The cursor advances with each issued read, so its lag counts down.
        if (issue_ok) begin
          ram_re         = 1'b1;
          cur_cmd.op     = fsr_pkg::CUR_STEP;
          rd_pend_d      = 1'b1;
          pend_pending_d = fsr_pkg::sat32(lag_left);
          pend_last_d    = (rem_q == fsr_pkg::BurstW'(1));
          rem_d          = rem_q - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= fsr_pkg::ST_IDLE;
      rem_q     <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rem_q     <= rem_d;
      rd_pend_q <= rd_pend_d;
    end
  end

  fsr_cursor_table u_cursor_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cur_cmd),
    .cap_i  (cap),
    .stat_o (cur_stat)
  );

  fsr_ram #(
    .Width (fsr_pkg::SampleBits),
    .Depth (fsr_pkg::Depth)
  ) u_sample_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cur_stat.wr_addr & mask),
    .wdata_i (sample_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Burst data returns in the cycle after its read; it never meets an execute push.
  always_comb begin
    fifo_push = rd_pend_q || exec_push;
    if (rd_pend_q) begin
      fifo_data.status  = fsr_pkg::STS_OK;
      fifo_data.sample  = ram_rdata;
      fifo_data.cursor  = '0;
      fifo_data.pending = pend_pending_q;
      fifo_data.last    = pend_last_q;
    end else begin
      fifo_data = exec_res;
    end
  end

  fsr_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fifo_push),
    .push_data_i (fifo_data),
    .pop_ready_i (m_axis_tready_i),
    .valid_o     (fifo_valid),
    .data_o      (fifo_out),
    .cnt_o       (fifo_cnt)
  );

  assign m_axis_tvalid_o = fifo_valid;
  assign m_axis_tdata_o  = {5'd0, fifo_out.pending, fifo_out.cursor, fifo_out.sample};
  assign m_axis_tuser_o  = fifo_out.status;
  assign m_axis_tlast_o  = fifo_out.last;

endmodule

FILE: design/fsr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module fsr_ram #(
  parameter int Width = 32,
  parameter int Depth = 4096,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/fsr_cursor_table.sv
// Write position and reader cursor table with per-lane overrun detection.
module fsr_cursor_table (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  fsr_pkg::cur_cmd_t       cmd_i,
  input  logic [fsr_pkg::CapW-1:0] cap_i,
  output fsr_pkg::cur_stat_t      stat_o
);

  logic [fsr_pkg::PosW-1:0]   wp_q, wp_d;
  logic [fsr_pkg::PosW-1:0]   pos_q [fsr_pkg::Fanout];
  logic [fsr_pkg::PosW-1:0]   pos_d [fsr_pkg::Fanout];
  logic [fsr_pkg::PosW-1:0]   lane_lag [fsr_pkg::Fanout];
  logic [fsr_pkg::Fanout-1:0] active_q, active_d;
  logic [fsr_pkg::Fanout-1:0] overrun_q, overrun_d;
  logic [fsr_pkg::Fanout-1:0] lane_full;
  logic                       sel_valid;
  logic [fsr_pkg::CurW-1:0]   idx;
  logic                       free_found;
  logic [fsr_pkg::CurW-1:0]   free_idx;

  assign sel_valid = (32'(cmd_i.sel) < 32'(fsr_pkg::Fanout));
  assign idx       = cmd_i.sel[fsr_pkg::CurW-1:0];

  // Every lane compares its own lag; a write pushes any active lane at capacity over.
  always_comb begin
    for (int i = 0; i < fsr_pkg::Fanout; i++) begin
      lane_lag[i]  = wp_q - pos_q[i];
      lane_full[i] = active_q[i] && (lane_lag[i] >= fsr_pkg::PosW'(cap_i));
    end
  end

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = fsr_pkg::Fanout - 1; i >= 0; i--) begin
      if (!active_q[i]) begin
        free_found = 1'b1;
        free_idx   = fsr_pkg::CurW'(i);
      end
    end
  end

  always_comb begin
    wp_d      = wp_q;
    pos_d     = pos_q;
    active_d  = active_q;
    overrun_d = overrun_q;
    unique case (cmd_i.op)
      fsr_pkg::CUR_WRITE: begin
        wp_d      = wp_q + 1'b1;
        overrun_d = overrun_q | lane_full;
      end
      fsr_pkg::CUR_ATTACH: begin
        if (free_found) begin
          active_d[free_idx]  = 1'b1;
          overrun_d[free_idx] = 1'b0;
          pos_d[free_idx]     = wp_q;
        end
      end
      fsr_pkg::CUR_DETACH: begin
        if (sel_valid) begin
          active_d[idx] = 1'b0;
        end
      end
      fsr_pkg::CUR_MARK: begin
        if (sel_valid) begin
          overrun_d[idx] = 1'b1;
        end
      end
      fsr_pkg::CUR_STEP: begin
        if (sel_valid) begin
          pos_d[idx] = pos_q[idx] + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q      <= '0;
      active_q  <= '0;
      overrun_q <= '0;
      for (int i = 0; i < fsr_pkg::Fanout; i++) begin
        pos_q[i] <= '0;
      end
    end else begin
      wp_q      <= wp_d;
      active_q  <= active_d;
      overrun_q <= overrun_d;
      pos_q     <= pos_d;
    end
  end

  always_comb begin
    stat_o.free_found  = free_found;
    stat_o.free_idx    = free_idx;
    stat_o.sel_active  = sel_valid && active_q[idx];
    stat_o.sel_overrun = overrun_q[idx];
    stat_o.sel_lag     = lane_lag[idx];
    stat_o.sel_addr    = pos_q[idx][fsr_pkg::AddrW-1:0];
    stat_o.wr_addr     = wp_q[fsr_pkg::AddrW-1:0];
  end

endmodule

FILE: design/fsr_out_fifo.sv
// Small result queue that decouples the result stream from the sequencer.
module fsr_out_fifo (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  fsr_pkg::res_t                push_data_i,
  input  logic                         pop_ready_i,
  output logic                         valid_o,
  output fsr_pkg::res_t                data_o,
  output logic [fsr_pkg::FifoCntW-1:0] cnt_o
);

  fsr_pkg::res_t                 mem_q [fsr_pkg::FifoDepth];
  logic [fsr_pkg::FifoPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [fsr_pkg::FifoPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [fsr_pkg::FifoCntW-1:0]  cnt_q, cnt_d;
  logic                          pop;

  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o && pop_ready_i;
  assign data_o  = mem_q[rd_ptr_q];
  assign cnt_o   = cnt_q;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + fsr_pkg::FifoCntW'(push_i) - fsr_pkg::FifoCntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

FILE: design/fsr_checker.sv
// Port-level checks of the fan-out sample ring, bound to the top level.
module fsr_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid_i,
  input logic                         s_axis_tready_o,
  input logic                         m_axis_tvalid_o,
  input logic                         m_axis_tready_i,
  input logic [fsr_pkg::OutDataW-1:0] m_axis_tdata_o,
  input logic [fsr_pkg::StatusW-1:0]  m_axis_tuser_o,
  input logic                         m_axis_tlast_o
);

  // A result stays offered until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result withdrawn before it was taken");

  // Nothing can be delivered in the first cycle after reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !m_axis_tvalid_o)
    else $error("result offered right after reset");

  // Each transaction is executed before the next one is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("transaction taken during execution");

  // A result that is not ok is always the single, sample-free answer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o != fsr_pkg::STS_OK) |->
      m_axis_tlast_o && (m_axis_tdata_o[31:0] == '0) && (m_axis_tdata_o[34:32] == '0))
    else $error("failing result carries data or is not last");

  // A claimed cursor index only comes with an attach answer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[34:32] != '0) |->
      m_axis_tlast_o && (m_axis_tdata_o[66:35] == '0) && (m_axis_tdata_o[31:0] == '0))
    else $error("cursor index mixed with read data");

endmodule

bind fanout_sample_ring fsr_checker u_fsr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
